[hw/rtl/fmtmr_pkg.sv]
package fmtmr_pkg;

  localparam int unsigned DEF_CYCLES_PER_SAMPLE = 144;
  localparam int unsigned DEF_BUSY_CYCLES       = 192;

  // timer A period in samples: TA_SPAN - setting
  localparam int unsigned TA_SPAN  = 32'h400 + 1;
  // timer B period in samples: 1 + TB_STEP * (TB_SPAN - setting)
  localparam int unsigned TB_SPAN  = 32'h100;
  localparam int unsigned TB_STEP  = 16;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    FUNC_LATCH   = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_ADVANCE = 2'd2
  } func_e;

  localparam logic [7:0] REG_TA_HI = 8'h24;
  localparam logic [7:0] REG_TA_LO = 8'h25;
  localparam logic [7:0] REG_TB    = 8'h26;
  localparam logic [7:0] REG_CTRL  = 8'h27;

  localparam logic [1:0] MODE_CSM = 2'b10;

  typedef struct packed {
    func_e       func;
    logic        port;
    logic [7:0]  byte_value;
    logic [15:0] cycles;
    logic [15:0] whole_frames;
  } item_t;

  typedef struct packed {
    logic [7:0] status;
    logic [8:0] frames_due;
    logic       csm_key_pulse;
    logic       fm3_special_mode;
  } result_t;

endpackage

[hw/rtl/fmtmr_in_stage.sv]
module fmtmr_in_stage import fmtmr_pkg::*; #(
  parameter int unsigned CYCLES_PER_SAMPLE = DEF_CYCLES_PER_SAMPLE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic [IN_USER_W-1:0] s_axis_tuser_i,
  input  logic                 take_i,
  output logic                 item_valid_o,
  output item_t                item_o
);

  // exact reciprocal for a 16-bit dividend
  localparam int unsigned     SHIFT = 16 + $clog2(CYCLES_PER_SAMPLE);
  localparam int unsigned     PW    = SHIFT + 16;
  localparam longint unsigned RECIP =
    ((longint'(1) << SHIFT) + longint'(CYCLES_PER_SAMPLE) - 1) / longint'(CYCLES_PER_SAMPLE);

  logic          valid_q, valid_d;
  item_t         item_q;
  logic [15:0]   cycles;
  logic [PW-1:0] prod;
  logic          accept;

  assign cycles          = s_axis_tdata_i[23:8];
  assign prod            = PW'(cycles) * PW'(RECIP);
  assign s_axis_tready_o = !valid_q || take_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.func         <= func_e'(s_axis_tuser_i[1:0]);
      item_q.port         <= s_axis_tuser_i[2];
      item_q.byte_value   <= s_axis_tdata_i[7:0];
      item_q.cycles       <= cycles;
      item_q.whole_frames <= prod[SHIFT +: 16];
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[hw/rtl/fmtmr_core.sv]
module fmtmr_core import fmtmr_pkg::*; #(
  parameter int unsigned CYCLES_PER_SAMPLE = DEF_CYCLES_PER_SAMPLE,
  parameter int unsigned BUSY_CYCLES       = DEF_BUSY_CYCLES
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    take_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam int unsigned TW = $clog2(CYCLES_PER_SAMPLE * (1 + TB_STEP * TB_SPAN) + 1);
  localparam int unsigned CW = (TW > 16) ? TW : 16;
  localparam int unsigned LW = (CYCLES_PER_SAMPLE > 1) ? $clog2(CYCLES_PER_SAMPLE) : 1;
  localparam int unsigned BW = $clog2(BUSY_CYCLES + 1);

  logic          lat_port_q, lat_port_d;
  logic [7:0]    lat_reg_q, lat_reg_d;
  logic [9:0]    ta_set_q, ta_set_d;
  logic [TW-1:0] ta_reload_q, ta_reload_d;
  logic [TW-1:0] tb_reload_q, tb_reload_d;
  logic [TW-1:0] ta_count_q, ta_count_d;
  logic [TW-1:0] tb_count_q, tb_count_d;
  logic [1:0]    flag_en_q, flag_en_d;
  logic [1:0]    last_load_q, last_load_d;
  logic [1:0]    flags_q, flags_d;
  logic [BW-1:0] busy_q, busy_d;
  logic [LW-1:0] left_q, left_d;
  logic          csm_q, csm_d;
  logic          per_op_q, per_op_d;

  logic [10:0]   ta_periods;
  logic [12:0]   tb_periods;
  logic [TW-1:0] ta_reload_calc, tb_reload_calc;
  logic [9:0]    ta_set_new;
  logic [15:0]   rem;
  logic [LW:0]   sum;
  logic          wrap;
  logic [TW:0]   ta_run, tb_run;
  logic [7:0]    d;
  logic          pulse;
  logic [8:0]    frames;

  // returns {expired, next count}
  function automatic logic [TW:0] run_timer(input logic [TW-1:0] count,
                                            input logic [TW-1:0] reload,
                                            input logic [15:0]   cyc);
    logic [TW:0] res;
    if (count == '0) begin
      res = {1'b0, count};
    end else if (CW'(count) <= CW'(cyc)) begin
      res = {1'b1, reload};
    end else begin
      res = {1'b0, TW'(CW'(count) - CW'(cyc))};
    end
    return res;
  endfunction

  assign d = item_i.byte_value;

  always_comb begin
    ta_set_new = ta_set_q;
    if (lat_reg_q == REG_TA_HI) begin
      ta_set_new = {d, ta_set_q[1:0]};
    end else if (lat_reg_q == REG_TA_LO) begin
      ta_set_new = {ta_set_q[9:2], d[1:0]};
    end
  end

  assign ta_periods     = 11'(TA_SPAN) - {1'b0, ta_set_new};
  assign tb_periods     = 13'd1 + 13'((9'(TB_SPAN) - {1'b0, d}) * 13'(TB_STEP));
  assign ta_reload_calc = TW'(ta_periods) * TW'(CYCLES_PER_SAMPLE);
  assign tb_reload_calc = TW'(tb_periods) * TW'(CYCLES_PER_SAMPLE);

  // frame pacing: remainder of this advance plus the carried remainder stays below 2 frames
  assign rem  = item_i.cycles - 16'(32'(item_i.whole_frames) * 32'(CYCLES_PER_SAMPLE));
  assign sum  = (LW + 1)'(left_q) + (LW + 1)'(rem);
  assign wrap = sum >= (LW + 1)'(CYCLES_PER_SAMPLE);

  assign ta_run = run_timer(ta_count_q, ta_reload_q, item_i.cycles);
  assign tb_run = run_timer(tb_count_q, tb_reload_q, item_i.cycles);

  always_comb begin
    lat_port_d  = lat_port_q;
    lat_reg_d   = lat_reg_q;
    ta_set_d    = ta_set_q;
    ta_reload_d = ta_reload_q;
    tb_reload_d = tb_reload_q;
    ta_count_d  = ta_count_q;
    tb_count_d  = tb_count_q;
    flag_en_d   = flag_en_q;
    last_load_d = last_load_q;
    flags_d     = flags_q;
    busy_d      = busy_q;
    left_d      = left_q;
    csm_d       = csm_q;
    per_op_d    = per_op_q;
    pulse       = 1'b0;
    frames      = '0;
    unique case (item_i.func)
      FUNC_LATCH: begin
        lat_port_d = item_i.port;
        lat_reg_d  = d;
      end
      FUNC_WRITE: begin
        busy_d = BW'(BUSY_CYCLES);
        if (!lat_port_q) begin
          if (lat_reg_q == REG_TA_HI || lat_reg_q == REG_TA_LO) begin
            ta_set_d    = ta_set_new;
            ta_reload_d = ta_reload_calc;
          end else if (lat_reg_q == REG_TB) begin
            tb_reload_d = tb_reload_calc;
          end else if (lat_reg_q == REG_CTRL) begin
            if (d[0] && !last_load_q[0]) begin
              ta_count_d = ta_reload_q;
            end
            if (d[1] && !last_load_q[1]) begin
              tb_count_d = tb_reload_q;
            end
            flag_en_d   = d[3:2];
            flags_d     = flags_q & ~d[5:4];
            last_load_d = d[1:0];
            per_op_d    = |d[7:6];
            csm_d       = d[7:6] == MODE_CSM;
          end
        end
      end
      FUNC_ADVANCE: begin
        left_d     = wrap ? LW'(sum - (LW + 1)'(CYCLES_PER_SAMPLE)) : LW'(sum);
        frames     = item_i.whole_frames[8:0] + 9'(wrap);
        ta_count_d = ta_run[TW-1:0];
        tb_count_d = tb_run[TW-1:0];
        flags_d    = flags_q | {tb_run[TW] & flag_en_q[1], ta_run[TW] & flag_en_q[0]};
        pulse      = ta_run[TW] & csm_q;
        busy_d     = (16'(busy_q) <= item_i.cycles) ? '0 : BW'(16'(busy_q) - item_i.cycles);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_port_q  <= 1'b0;
      lat_reg_q   <= '0;
      ta_set_q    <= '0;
      ta_reload_q <= TW'(CYCLES_PER_SAMPLE);
      tb_reload_q <= TW'(CYCLES_PER_SAMPLE);
      ta_count_q  <= TW'(CYCLES_PER_SAMPLE);
      tb_count_q  <= TW'(CYCLES_PER_SAMPLE);
      flag_en_q   <= '0;
      last_load_q <= '0;
      flags_q     <= '0;
      busy_q      <= '0;
      left_q      <= '0;
      csm_q       <= 1'b0;
      per_op_q    <= 1'b0;
    end else if (take_i) begin
      lat_port_q  <= lat_port_d;
      lat_reg_q   <= lat_reg_d;
      ta_set_q    <= ta_set_d;
      ta_reload_q <= ta_reload_d;
      tb_reload_q <= tb_reload_d;
      ta_count_q  <= ta_count_d;
      tb_count_q  <= tb_count_d;
      flag_en_q   <= flag_en_d;
      last_load_q <= last_load_d;
      flags_q     <= flags_d;
      busy_q      <= busy_d;
      left_q      <= left_d;
      csm_q       <= csm_d;
      per_op_q    <= per_op_d;
    end
  end

  assign result_o.status           = {busy_d != '0, 5'b0, flags_d};
  assign result_o.frames_due       = frames;
  assign result_o.csm_key_pulse    = pulse;
  assign result_o.fm3_special_mode = per_op_d;

endmodule

[hw/rtl/fmtmr_out_stage.sv]
module fmtmr_out_stage import fmtmr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  result_t               result_i,
  output logic                  room_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign room_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {5'b0, result_q.fm3_special_mode, result_q.csm_key_pulse,
                            result_q.frames_due, result_q.status};

endmodule

[hw/rtl/fm_chip_timer_status_block.sv]
// Path: an accepted request waits in the input register, then passes through the core
// into the result register once that register has room, and shows on the result port.
// Throughput: one request per cycle while the result port is not stalled; the core's
// decrement, compare and frame-remainder logic sits between those two registers.
// Reset (async, active low) clears all flags, busy and latched address, and sets
// both timer counts and reloads to one sample period.
module fm_chip_timer_status_block import fmtmr_pkg::*; #(
  parameter int unsigned CYCLES_PER_SAMPLE = DEF_CYCLES_PER_SAMPLE,
  parameter int unsigned BUSY_CYCLES       = DEF_BUSY_CYCLES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // byte_value[7:0], cycles[23:8]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,   // func[1:0], port[2]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o    // status[7:0], frames_due[16:8],
                                                  // csm_key_pulse[17], fm3_special_mode[18]
);

  logic    item_valid;
  item_t   item;
  logic    room;
  logic    take;
  result_t result;

  assign take = item_valid && room;

  fmtmr_in_stage #(
    .CYCLES_PER_SAMPLE(CYCLES_PER_SAMPLE)
  ) u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .take_i         (take),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  fmtmr_core #(
    .CYCLES_PER_SAMPLE(CYCLES_PER_SAMPLE),
    .BUSY_CYCLES      (BUSY_CYCLES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (item),
    .result_o(result)
  );

  fmtmr_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (take),
    .result_i       (result),
    .room_o         (room),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

endmodule

[hw/rtl/fmtmr_checker.sv]
module fmtmr_checker import fmtmr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_USER_W-1:0]  s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic in_req;

  assign in_req = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a data write shows busy in its own result
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req && s_axis_tuser_i[1:0] == FUNC_WRITE ##1 m_axis_tready_i
      |=> m_axis_tvalid_o && m_axis_tdata_o[7])
    else $error("write request did not report busy");

  // an address latch reports no frames and no CSM key
  a_latch_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req && s_axis_tuser_i[1:0] == FUNC_LATCH ##1 m_axis_tready_i
      |=> m_axis_tvalid_o && m_axis_tdata_o[17:8] == '0)
    else $error("latch request reported frames or CSM key");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid coming out of reset");

endmodule

bind fm_chip_timer_status_block fmtmr_checker u_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fmtmr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 8;

  class timer_scoreboard;
    bit        bank;
    bit [7:0]  reg_addr;
    bit [9:0]  ta_setting;
    bit [19:0] ta_reload;
    bit [19:0] tb_reload;
    bit [19:0] ta_count;
    bit [19:0] tb_count;
    bit [1:0]  flag_en;
    bit [1:0]  flags;
    bit [7:0]  ctrl_prev;
    bit [7:0]  busy_left;
    bit [7:0]  frac_cycles;
    bit        csm_on;
    bit        fm3_mode;
    result_t   pending_q[$];
    int        errors;

    function new();
      ta_reload = 20'(DEF_CYCLES_PER_SAMPLE);
      tb_reload = 20'(DEF_CYCLES_PER_SAMPLE);
      ta_count  = 20'(DEF_CYCLES_PER_SAMPLE);
      tb_count  = 20'(DEF_CYCLES_PER_SAMPLE);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Counter clamps at zero, reloads on expiry, overshoot is lost.
    function bit timer_expires(inout bit [19:0] count, input bit [19:0] reload,
                               input bit [15:0] cycles);
      if (count == 0) return 1'b0;
      count = (count < cycles) ? 20'd0 : count - cycles;
      if (count != 0) return 1'b0;
      count = reload;
      return 1'b1;
    endfunction

    function void apply_write(bit [7:0] value);
      busy_left = 8'(DEF_BUSY_CYCLES);
      if (bank) return;
      case (reg_addr)
        REG_TA_HI: begin
          ta_setting = {value, ta_setting[1:0]};
          ta_reload  = 20'(DEF_CYCLES_PER_SAMPLE * (TA_SPAN - ta_setting));
        end
        REG_TA_LO: begin
          ta_setting[1:0] = value[1:0];
          ta_reload       = 20'(DEF_CYCLES_PER_SAMPLE * (TA_SPAN - ta_setting));
        end
        REG_TB: tb_reload = 20'(DEF_CYCLES_PER_SAMPLE * (1 + TB_STEP * (TB_SPAN - value)));
        REG_CTRL: begin
          if (value[0] && !ctrl_prev[0]) ta_count = ta_reload;
          if (value[1] && !ctrl_prev[1]) tb_count = tb_reload;
          flag_en   = value[3:2];
          flags     = flags & ~value[5:4];
          ctrl_prev = value;
          fm3_mode  = (value[7:6] != 2'b00);
          csm_on    = (value[7:6] == MODE_CSM);
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] func, logic port, logic [7:0] value,
                               logic [15:0] cycles);
      result_t     want;
      int unsigned total;
      want = '0;
      case (func)
        FUNC_LATCH: begin
          bank     = port;
          reg_addr = value;
        end
        FUNC_WRITE: apply_write(value);
        FUNC_ADVANCE: begin
          total           = frac_cycles + cycles;
          want.frames_due = 9'(total / DEF_CYCLES_PER_SAMPLE);
          frac_cycles     = 8'(total % DEF_CYCLES_PER_SAMPLE);
          if (timer_expires(ta_count, ta_reload, cycles)) begin
            if (flag_en[0]) flags[0] = 1'b1;
            if (csm_on) want.csm_key_pulse = 1'b1;
          end
          if (timer_expires(tb_count, tb_reload, cycles) && flag_en[1]) flags[1] = 1'b1;
          busy_left = (busy_left < cycles) ? 8'd0 : busy_left - 8'(cycles);
        end
        default: ;
      endcase
      want.status           = {busy_left != 0, 5'b0, flags};
      want.fm3_special_mode = fm3_mode;
      pending_q.push_back(want);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, data);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (data[7:0] !== want.status) begin
        $display("%0t: status expected %h got %h", $time, want.status, data[7:0]);
        errors++;
      end
      if (data[16:8] !== want.frames_due) begin
        $display("%0t: frames_due expected %0d got %0d", $time, want.frames_due, data[16:8]);
        errors++;
      end
      if (data[17] !== want.csm_key_pulse) begin
        $display("%0t: csm_key_pulse expected %b got %b", $time, want.csm_key_pulse,
                 data[17]);
        errors++;
      end
      if (data[18] !== want.fm3_special_mode) begin
        $display("%0t: fm3_special_mode expected %b got %b", $time, want.fm3_special_mode,
                 data[18]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;   // byte_value[7:0], cycles[23:8]
  logic [IN_USER_W-1:0]  s_axis_tuser_i = '0;   // func[1:0], port[2]
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;        // status[7:0], frames_due[16:8],
                                                // csm_key_pulse[17], fm3_special_mode[18]

  timer_scoreboard sb = new();
  bit hold_off;
  bit hold_active;
  int burst_left;

  fm_chip_timer_status_block dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // result side: rotating stall patterns, plus one long hold-off on request
  initial begin
    int rx_cycle;
    int mode;
    rx_cycle = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        hold_active = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off    = 1'b0;
        hold_active = 1'b0;
      end else begin
        rx_cycle++;
        mode = (rx_cycle / 97) % 4;
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= 1'($urandom_range(1));
          2: m_axis_tready_i <= (rx_cycle % 4 == 0);
          default: m_axis_tready_i <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic [1:0] func, input logic port, input logic [7:0] value,
                           input logic [15:0] cycles);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {cycles, value};
    s_axis_tuser_i  <= {port, func};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(func, port, value, cycles);
  endtask

  task automatic idle_sender(input int n);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // bursts of random length, random gaps; no gaps while the result side holds off
  task automatic pace();
    if (hold_off || hold_active) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_sender($urandom_range(1, 6));
      burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 16);
    end
  endtask

  task automatic request(input logic [1:0] func, input logic port, input logic [7:0] value,
                         input logic [15:0] cycles);
    send_item(func, port, value, cycles);
    pace();
  endtask

  task automatic write_reg(input logic port, input logic [7:0] addr, input logic [7:0] value);
    request(FUNC_LATCH, port, addr, 16'($urandom));
    request(FUNC_WRITE, 1'($urandom), value, 16'($urandom));
  endtask

  initial begin
    logic [7:0]  timer_regs[4];
    logic [7:0]  addr;
    logic [15:0] cycles;
    int          n;
    int          pick;
    int          wait_cycles;
    bit          held;
    bit          drained;

    timer_regs = '{REG_TA_HI, REG_TA_LO, REG_TB, REG_CTRL};
    burst_left = 4;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed
    request(FUNC_ADVANCE, 1'b0, 8'h00, 16'd0);
    request(FUNC_UNUSED, 1'b1, 8'hFF, 16'hFFFF);
    write_reg(1'b0, REG_TA_HI, 8'hFF);
    write_reg(1'b0, REG_TA_LO, 8'h03);        // shortest timer A
    write_reg(1'b0, REG_TB, 8'hFF);           // shortest timer B
    write_reg(1'b0, REG_CTRL, 8'h8F);         // load both, enable both, CSM
    request(FUNC_ADVANCE, 1'b0, 8'h00, 16'hFFFF);
    request(FUNC_WRITE, 1'b0, 8'h8F, 16'd0);  // load bits held, no reload
    request(FUNC_WRITE, 1'b0, 8'hBF, 16'd0);  // clear both flags
    request(FUNC_WRITE, 1'b0, 8'h00, 16'd0);
    request(FUNC_WRITE, 1'b0, 8'hC3, 16'd0);  // load edge, per-op mode, flags disabled
    request(FUNC_ADVANCE, 1'b0, 8'h00, 16'd300);
    request(FUNC_ADVANCE, 1'b0, 8'h00, 16'd1);
    write_reg(1'b1, REG_CTRL, 8'h00);         // bank one only sets busy
    write_reg(1'b0, 8'h30, 8'h55);
    request(FUNC_ADVANCE, 1'b0, 8'h00, 16'd100);
    request(FUNC_ADVANCE, 1'b0, 8'h00, 16'd143);
    write_reg(1'b0, REG_TA_HI, 8'h00);

    // random
    n       = 0;
    held    = 1'b0;
    drained = 1'b0;
    while (n < ITEM_TARGET) begin
      if (!held && n >= 150) begin
        held     = 1'b1;
        hold_off = 1'b1;
      end
      if (!drained && n >= 350) begin
        drained = 1'b1;
        idle_sender(1);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        addr = ($urandom_range(4) == 0) ? 8'($urandom) : timer_regs[2'($urandom_range(3))];
        write_reg($urandom_range(9) == 0, addr, 8'($urandom));
        n += 2;
      end else if (pick < 80) begin
        case ($urandom_range(9))
          0:          cycles = 16'd0;
          1, 2, 3, 4: cycles = 16'($urandom_range(300));
          5, 6, 7:    cycles = 16'($urandom_range(4000));
          default:    cycles = 16'($urandom_range(65535));
        endcase
        request(FUNC_ADVANCE, 1'($urandom), 8'($urandom), cycles);
        n++;
      end else if (pick < 88) begin
        request(FUNC_WRITE, 1'($urandom), 8'($urandom), 16'($urandom));
        n++;
      end else if (pick < 95) begin
        request(FUNC_LATCH, 1'($urandom), 8'($urandom), 16'($urandom));
        n++;
      end else begin
        request(FUNC_UNUSED, 1'($urandom), 8'($urandom), 16'($urandom));
      end
    end
    idle_sender(1);

    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/fmtmr_pkg.sv
hw/rtl/fmtmr_in_stage.sv
hw/rtl/fmtmr_core.sv
hw/rtl/fmtmr_out_stage.sv
hw/rtl/fm_chip_timer_status_block.sv
hw/rtl/fmtmr_checker.sv
tb/testbench.sv
